>>> rtl/omst_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// offline message slot table. No dependencies.
`default_nettype none

package omst_pkg;

  // Table geometry and limits.
  localparam int SLOTS   = 16;
  localparam int MAX_LEN = 256;
  localparam int ID_BITS = 64;

  // Fixed field widths of the channels.
  localparam int DEST_W     = 64;
  localparam int FLAGS_W    = 3;
  localparam int OP_W       = 8;
  localparam int LEN_W      = 10;
  localparam int TIME_W     = 32;
  localparam int ORDER_W    = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int COUNT_W    = 5;

  // Internal widths derived from the table size.
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Only the low ID_BITS bits of a destination take part.
  localparam logic [DEST_W-1:0] ID_MASK = {DEST_W{1'b1}} >> (DEST_W - ID_BITS);

  // Flag bit that marks a courier entry.
  localparam int FLAG_COURIER_BIT = 2;

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TTL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COURIER_TTL = 1'b1;
  localparam logic [TIME_W-1:0] NORMAL_TTL_RESET  = 32'd21600000;
  localparam logic [TIME_W-1:0] COURIER_TTL_RESET = 32'd86400000;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_STORED_FREE  = 3'd0,
    ST_STORED_EVICT = 3'd1,
    ST_REJECTED     = 3'd2,
    ST_DELIVERED    = 3'd3,
    ST_DEFERRED     = 3'd4,
    ST_EXPIRED      = 3'd5,
    ST_DONE         = 3'd6
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new input transaction
    logic enq_step;    // examine one slot for a free or victim candidate
    logic enq_commit;  // write the entry (or reject) and emit its result
    logic onl_step;    // examine one slot during an online scan
    logic done_emit;   // emit the closing done result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;    // captured enqueue is too long
    logic free_hit;  // slot under the index is free
    logic onl_hit;   // slot under the index produces an online result
    logic idx_last;  // index is at the last slot
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/offline_message_slot_table.sv
// Top level of the offline message slot table: controller plus datapath.
// Depends on omst_pkg, omst_ctrl and omst_dpath.
//
//   Channel  Handshake          Direction  Carries
//   in_      in_valid/in_stall  input      one enqueue or node-online transaction
//   out_     out_valid/out_stall output    results of each transaction (17 max)
//   cfg_     cfg_valid/cfg_ready input     TTL register write (index, data)
//
// One transaction at a time. An enqueue is captured, examines the slots one by
// one until a free one (all 16 if full), and commits; a too-long one skips the scan.
// A node-online event is captured, examines all 16 slots and emits the done
// result. Both walk the single slot scan over the entry registers.
// A stalled output register holds the scan at the next slot that reports.
// Synchronous active-low reset clears all slots, counters and the output.
`default_nettype none

module offline_message_slot_table (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic [omst_pkg::DEST_W-1:0]        in_dest_id,
  input  wire logic [omst_pkg::FLAGS_W-1:0]       in_msg_flags,
  input  wire logic [omst_pkg::OP_W-1:0]          in_msg_opcode,
  input  wire logic [omst_pkg::LEN_W-1:0]         in_payload_len,
  input  wire logic [omst_pkg::TIME_W-1:0]        in_now_ms,
  input  wire logic                               in_tx_accept,
  // Configuration channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [omst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [omst_pkg::TIME_W-1:0]        cfg_data,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [2:0]                              out_status,
  output logic [omst_pkg::SLOT_OUT_W-1:0]         out_slot,
  output logic [omst_pkg::DEST_W-1:0]             out_dest,
  output logic [omst_pkg::OP_W-1:0]               out_opcode,
  output logic [omst_pkg::FLAGS_W-1:0]            out_flags,
  output logic [omst_pkg::LEN_W-1:0]              out_len,
  output logic [omst_pkg::COUNT_W-1:0]            out_pending_count,
  output logic [omst_pkg::COUNT_W-1:0]            out_courier_count,
  output logic                                    out_last
);
  import omst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of capture, scan and result steps.
  omst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot storage, scan arithmetic and result register.
  omst_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_dest_id        (in_dest_id),
    .in_msg_flags      (in_msg_flags),
    .in_msg_opcode     (in_msg_opcode),
    .in_payload_len    (in_payload_len),
    .in_now_ms         (in_now_ms),
    .in_tx_accept      (in_tx_accept),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_dest          (out_dest),
    .out_opcode        (out_opcode),
    .out_flags         (out_flags),
    .out_len           (out_len),
    .out_pending_count (out_pending_count),
    .out_courier_count (out_courier_count),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire

>>> rtl/omst_ctrl.sv
// Controller state machine for the offline message slot table.
// Depends on omst_pkg for the command and status types.
`default_nettype none

module omst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_kind,
  output logic               in_stall,
  input  wire omst_pkg::sts_t sts,
  output omst_pkg::cmd_t     cmd
);
  import omst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_SCAN,
    S_ENQ_WRITE,
    S_ONL_SCAN,
    S_ONL_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Only an idle controller takes a new transaction.
  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_kind ? S_ONL_SCAN : S_ENQ_SCAN;
        end
      end
      S_ENQ_SCAN: begin
        if (sts.reject) begin
          state_nxt = S_ENQ_WRITE;
        end else begin
          cmd.enq_step = 1'b1;
          if (sts.free_hit || sts.idx_last) begin
            state_nxt = S_ENQ_WRITE;
          end
        end
      end
      S_ENQ_WRITE: begin
        if (sts.out_free) begin
          cmd.enq_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ONL_SCAN: begin
        // A slot that yields a result waits for room in the output register.
        if (!sts.onl_hit || sts.out_free) begin
          cmd.onl_step = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_ONL_DONE;
          end
        end
      end
      S_ONL_DONE: begin
        if (sts.out_free) begin
          cmd.done_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/omst_dpath.sv
// Datapath of the offline message slot table: entry storage, scan index,
// eviction candidates, occupancy counters, TTL registers and result register.
// Depends on omst_pkg.
`default_nettype none

module omst_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input fields
  input  wire logic [omst_pkg::DEST_W-1:0]        in_dest_id,
  input  wire logic [omst_pkg::FLAGS_W-1:0]       in_msg_flags,
  input  wire logic [omst_pkg::OP_W-1:0]          in_msg_opcode,
  input  wire logic [omst_pkg::LEN_W-1:0]         in_payload_len,
  input  wire logic [omst_pkg::TIME_W-1:0]        in_now_ms,
  input  wire logic                               in_tx_accept,
  // Configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [omst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [omst_pkg::TIME_W-1:0]        cfg_data,
  // Results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [2:0]                              out_status,
  output logic [omst_pkg::SLOT_OUT_W-1:0]         out_slot,
  output logic [omst_pkg::DEST_W-1:0]             out_dest,
  output logic [omst_pkg::OP_W-1:0]               out_opcode,
  output logic [omst_pkg::FLAGS_W-1:0]            out_flags,
  output logic [omst_pkg::LEN_W-1:0]              out_len,
  output logic [omst_pkg::COUNT_W-1:0]            out_pending_count,
  output logic [omst_pkg::COUNT_W-1:0]            out_courier_count,
  output logic                                    out_last,
  // Controller link
  input  wire omst_pkg::cmd_t                     cmd,
  output omst_pkg::sts_t                          sts
);
  import omst_pkg::*;

  // Entry storage; contents are meaningful only where the valid bit is set.
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [DEST_W-1:0]  dest_mem  [SLOTS];
  logic [FLAGS_W-1:0] flags_mem [SLOTS];
  logic [OP_W-1:0]    op_mem    [SLOTS];
  logic [LEN_W-1:0]   len_mem   [SLOTS];
  logic [ORDER_W-1:0] order_mem [SLOTS];
  logic [TIME_W-1:0]  time_mem  [SLOTS];

  // Captured transaction.
  logic [DEST_W-1:0]  dest_r;
  logic [FLAGS_W-1:0] flags_r;
  logic [OP_W-1:0]    op_r;
  logic [LEN_W-1:0]   len_r;
  logic [TIME_W-1:0]  now_r;
  logic               acc_r;

  // Scan index and enqueue candidates.
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic               free_fnd_r, free_fnd_nxt;
  logic [SLOT_W-1:0]  free_idx_r, free_idx_nxt;
  logic               norm_fnd_r, norm_fnd_nxt;
  logic [SLOT_W-1:0]  norm_idx_r, norm_idx_nxt;
  logic [ORDER_W-1:0] norm_ord_r, norm_ord_nxt;
  logic               cour_fnd_r, cour_fnd_nxt;
  logic [SLOT_W-1:0]  cour_idx_r, cour_idx_nxt;
  logic [ORDER_W-1:0] cour_ord_r, cour_ord_nxt;

  // Counters and configuration.
  logic [CNT_W-1:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]   ccnt_r, ccnt_nxt;
  logic [ORDER_W-1:0] order_cnt_r, order_cnt_nxt;
  logic [TIME_W-1:0]  normal_ttl_r, courier_ttl_r;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  status_t            ost_r, ost_nxt;
  logic [SLOT_W-1:0]  oslot_r, oslot_nxt;
  logic [DEST_W-1:0]  odest_r, odest_nxt;
  logic [OP_W-1:0]    oop_r, oop_nxt;
  logic [FLAGS_W-1:0] oflags_r, oflags_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;
  logic [CNT_W-1:0]   opend_r, opend_nxt;
  logic [CNT_W-1:0]   occnt_r, occnt_nxt;
  logic               olast_r, olast_nxt;

  // Current slot view and commit decode.
  logic               cur_valid, cur_courier, cur_exp, cur_match, cur_remove;
  logic [TIME_W-1:0]  cur_ttl, cur_age;
  logic               reject;
  logic               out_free;
  logic [SLOT_W-1:0]  tgt;
  logic               new_courier, old_courier;
  logic               wr_en;

  assign cfg_ready = 1'b1;

  // View of the slot under the scan index.
  always_comb begin
    cur_valid   = valid_r[idx_r];
    cur_courier = flags_mem[idx_r][FLAG_COURIER_BIT];
    cur_ttl     = cur_courier ? courier_ttl_r : normal_ttl_r;
    cur_age     = now_r - time_mem[idx_r];
    cur_exp     = (cur_age > cur_ttl);
    cur_match   = (dest_mem[idx_r] == dest_r);
    cur_remove  = cur_exp || acc_r;
  end

  assign reject   = (len_r > LEN_W'(MAX_LEN));
  assign out_free = !out_valid_r || !out_stall;

  // Enqueue target: free slot, else oldest normal entry, else oldest courier.
  assign tgt         = free_fnd_r ? free_idx_r : (norm_fnd_r ? norm_idx_r : cour_idx_r);
  assign new_courier = flags_r[FLAG_COURIER_BIT];
  assign old_courier = !free_fnd_r && !norm_fnd_r;
  assign wr_en       = cmd.enq_commit && !reject;

  always_comb begin
    sts.reject   = reject;
    sts.free_hit = !cur_valid;
    sts.onl_hit  = cur_valid && (cur_exp || cur_match);
    sts.idx_last = (idx_r == SLOT_W'(SLOTS - 1));
    sts.out_free = out_free;
  end

  // Next-state logic for control and result registers.
  always_comb begin
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    free_fnd_nxt  = free_fnd_r;
    free_idx_nxt  = free_idx_r;
    norm_fnd_nxt  = norm_fnd_r;
    norm_idx_nxt  = norm_idx_r;
    norm_ord_nxt  = norm_ord_r;
    cour_fnd_nxt  = cour_fnd_r;
    cour_idx_nxt  = cour_idx_r;
    cour_ord_nxt  = cour_ord_r;
    pend_nxt      = pend_r;
    ccnt_nxt      = ccnt_r;
    order_cnt_nxt = order_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    ost_nxt       = ost_r;
    oslot_nxt     = oslot_r;
    odest_nxt     = odest_r;
    oop_nxt       = oop_r;
    oflags_nxt    = oflags_r;
    olen_nxt      = olen_r;
    opend_nxt     = opend_r;
    occnt_nxt     = occnt_r;
    olast_nxt     = olast_r;

    if (cmd.load) begin
      idx_nxt      = '0;
      free_fnd_nxt = 1'b0;
      norm_fnd_nxt = 1'b0;
      cour_fnd_nxt = 1'b0;
    end

    // Enqueue scan: stop at a free slot, otherwise track the oldest per class.
    if (cmd.enq_step) begin
      idx_nxt = idx_r + SLOT_W'(1);
      if (!cur_valid) begin
        free_fnd_nxt = 1'b1;
        free_idx_nxt = idx_r;
      end else if (cur_courier) begin
        if (!cour_fnd_r || (order_mem[idx_r] < cour_ord_r)) begin
          cour_fnd_nxt = 1'b1;
          cour_idx_nxt = idx_r;
          cour_ord_nxt = order_mem[idx_r];
        end
      end else begin
        if (!norm_fnd_r || (order_mem[idx_r] < norm_ord_r)) begin
          norm_fnd_nxt = 1'b1;
          norm_idx_nxt = idx_r;
          norm_ord_nxt = order_mem[idx_r];
        end
      end
    end

    // Enqueue commit: store or reject, then report.
    if (cmd.enq_commit) begin
      out_valid_nxt = 1'b1;
      odest_nxt     = dest_r;
      oop_nxt       = op_r;
      oflags_nxt    = flags_r;
      olen_nxt      = len_r;
      olast_nxt     = 1'b1;
      if (reject) begin
        ost_nxt   = ST_REJECTED;
        oslot_nxt = '0;
      end else begin
        order_cnt_nxt  = order_cnt_r + ORDER_W'(1);
        valid_nxt[tgt] = 1'b1;
        oslot_nxt      = tgt;
        if (free_fnd_r) begin
          ost_nxt  = ST_STORED_FREE;
          pend_nxt = pend_r + CNT_W'(1);
        end else begin
          ost_nxt = ST_STORED_EVICT;
        end
        ccnt_nxt = ccnt_r - CNT_W'(old_courier) + CNT_W'(new_courier);
      end
      opend_nxt = pend_nxt;
      occnt_nxt = ccnt_nxt;
    end

    // Online scan: expire, deliver or defer the slot under the index.
    if (cmd.onl_step) begin
      idx_nxt = idx_r + SLOT_W'(1);
      if (sts.onl_hit) begin
        if (cur_remove) begin
          valid_nxt[idx_r] = 1'b0;
          pend_nxt         = pend_r - CNT_W'(1);
          ccnt_nxt         = ccnt_r - CNT_W'(cur_courier);
        end
        priority if (cur_exp) begin
          ost_nxt = ST_EXPIRED;
        end else if (acc_r) begin
          ost_nxt = ST_DELIVERED;
        end else begin
          ost_nxt = ST_DEFERRED;
        end
        out_valid_nxt = 1'b1;
        oslot_nxt     = idx_r;
        odest_nxt     = dest_mem[idx_r];
        oop_nxt       = op_mem[idx_r];
        oflags_nxt    = flags_mem[idx_r];
        olen_nxt      = len_mem[idx_r];
        opend_nxt     = pend_nxt;
        occnt_nxt     = ccnt_nxt;
        olast_nxt     = 1'b0;
      end
    end

    // Closing done result with the counts after the scan.
    if (cmd.done_emit) begin
      out_valid_nxt = 1'b1;
      ost_nxt       = ST_DONE;
      oslot_nxt     = '0;
      odest_nxt     = '0;
      oop_nxt       = '0;
      oflags_nxt    = '0;
      olen_nxt      = '0;
      opend_nxt     = pend_r;
      occnt_nxt     = ccnt_r;
      olast_nxt     = 1'b1;
    end
  end

  // Control registers, counters and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      idx_r         <= '0;
      free_fnd_r    <= 1'b0;
      norm_fnd_r    <= 1'b0;
      cour_fnd_r    <= 1'b0;
      pend_r        <= '0;
      ccnt_r        <= '0;
      order_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
      normal_ttl_r  <= NORMAL_TTL_RESET;
      courier_ttl_r <= COURIER_TTL_RESET;
    end else begin
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      free_fnd_r  <= free_fnd_nxt;
      norm_fnd_r  <= norm_fnd_nxt;
      cour_fnd_r  <= cour_fnd_nxt;
      pend_r      <= pend_nxt;
      ccnt_r      <= ccnt_nxt;
      order_cnt_r <= order_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_NORMAL_TTL:  normal_ttl_r  <= cfg_data;
          CFG_COURIER_TTL: courier_ttl_r <= cfg_data;
        endcase
      end
    end
  end

  // Payload registers: captured fields, candidates, result and entry storage.
  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    norm_idx_r <= norm_idx_nxt;
    norm_ord_r <= norm_ord_nxt;
    cour_idx_r <= cour_idx_nxt;
    cour_ord_r <= cour_ord_nxt;
    ost_r      <= ost_nxt;
    oslot_r    <= oslot_nxt;
    odest_r    <= odest_nxt;
    oop_r      <= oop_nxt;
    oflags_r   <= oflags_nxt;
    olen_r     <= olen_nxt;
    opend_r    <= opend_nxt;
    occnt_r    <= occnt_nxt;
    olast_r    <= olast_nxt;
    if (cmd.load) begin
      dest_r  <= in_dest_id & ID_MASK;
      flags_r <= in_msg_flags;
      op_r    <= in_msg_opcode;
      len_r   <= in_payload_len;
      now_r   <= in_now_ms;
      acc_r   <= in_tx_accept;
    end
    if (wr_en) begin
      dest_mem[tgt]  <= dest_r;
      flags_mem[tgt] <= flags_r;
      op_mem[tgt]    <= op_r;
      len_mem[tgt]   <= len_r;
      order_mem[tgt] <= order_cnt_nxt;
      time_mem[tgt]  <= now_r;
    end
  end

  // Result port.
  assign out_valid         = out_valid_r;
  assign out_status        = ost_r;
  assign out_slot          = SLOT_OUT_W'(oslot_r);
  assign out_dest          = odest_r;
  assign out_opcode        = oop_r;
  assign out_flags         = oflags_r;
  assign out_len           = olen_r;
  assign out_pending_count = COUNT_W'(opend_r);
  assign out_courier_count = COUNT_W'(occnt_r);
  assign out_last          = olast_r;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the offline message slot table: stores, evictions,
// rejections, expiry, delivery and deferral, checked against an internal predictor.
// Depends on omst_pkg and offline_message_slot_table.
`default_nettype none

module tb_top;
  import omst_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int POOL_SIZE     = 6;

  // One enqueue or node-online transaction on the input channel.
  typedef struct {
    bit                 kind;
    bit [DEST_W-1:0]    dest;
    bit [FLAGS_W-1:0]   flags;
    bit [OP_W-1:0]      opcode;
    bit [LEN_W-1:0]     len;
    bit [TIME_W-1:0]    now;
    bit                 accept;
  } msg_event_t;

  // One result transaction on the output channel.
  typedef struct {
    status_t              status;
    bit [SLOT_OUT_W-1:0]  slot;
    bit [DEST_W-1:0]      dest;
    bit [OP_W-1:0]        opcode;
    bit [FLAGS_W-1:0]     flags;
    bit [LEN_W-1:0]       len;
    bit [COUNT_W-1:0]     pending;
    bit [COUNT_W-1:0]     couriers;
    bit                   last;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_kind = 1'b0;
  logic [DEST_W-1:0]     in_dest_id = '0;
  logic [FLAGS_W-1:0]    in_msg_flags = '0;
  logic [OP_W-1:0]       in_msg_opcode = '0;
  logic [LEN_W-1:0]      in_payload_len = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  in_tx_accept = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TIME_W-1:0]     cfg_data = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_status;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [DEST_W-1:0]     out_dest;
  logic [OP_W-1:0]       out_opcode;
  logic [FLAGS_W-1:0]    out_flags;
  logic [LEN_W-1:0]      out_len;
  logic [COUNT_W-1:0]    out_pending_count;
  logic [COUNT_W-1:0]    out_courier_count;
  logic                  out_last;

  offline_message_slot_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_dest_id        (in_dest_id),
    .in_msg_flags      (in_msg_flags),
    .in_msg_opcode     (in_msg_opcode),
    .in_payload_len    (in_payload_len),
    .in_now_ms         (in_now_ms),
    .in_tx_accept      (in_tx_accept),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_dest          (out_dest),
    .out_opcode        (out_opcode),
    .out_flags         (out_flags),
    .out_len           (out_len),
    .out_pending_count (out_pending_count),
    .out_courier_count (out_courier_count),
    .out_last          (out_last)
  );

  // Free-running clock, period 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the slot table and its lifetime registers.
  bit                slot_used   [SLOTS];
  bit [DEST_W-1:0]   slot_dest   [SLOTS];
  bit [FLAGS_W-1:0]  slot_flags  [SLOTS];
  bit [OP_W-1:0]     slot_opcode [SLOTS];
  bit [LEN_W-1:0]    slot_len    [SLOTS];
  bit [ORDER_W-1:0]  slot_seq    [SLOTS];
  bit [TIME_W-1:0]   slot_stamp  [SLOTS];
  bit [ORDER_W-1:0]  seq_counter = '0;
  bit [TIME_W-1:0]   ttl_normal  = NORMAL_TTL_RESET;
  bit [TIME_W-1:0]   ttl_courier = COURIER_TTL_RESET;

  slot_report_t awaited_reports[$];
  msg_event_t   offered_msgs[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int items_queued   = 0;
  int items_accepted = 0;

  // Stimulus-side controls.
  bit            idle_en = 1'b1;
  int            hold_seq = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            stall_left = 0;
  int            send_gap = 0;
  bit [TIME_W-1:0] plan_ttl_normal  = NORMAL_TTL_RESET;
  bit [TIME_W-1:0] plan_ttl_courier = COURIER_TTL_RESET;
  bit [TIME_W-1:0] wall_ms = '0;
  bit [DEST_W-1:0] dest_pool [POOL_SIZE];

  // Print one mismatch line and count it.
  task automatic note_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                              results_seen, name, got, want));
  endtask

  // Append one expected result, with the occupancy counts as they stand now.
  function automatic void queue_report(status_t st, int slot, bit [DEST_W-1:0] dest,
                                       bit [OP_W-1:0] op, bit [FLAGS_W-1:0] flags,
                                       bit [LEN_W-1:0] len, bit last_flag);
    slot_report_t rep;
    int pend;
    int cour;
    pend = 0;
    cour = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        pend++;
        if (slot_flags[i][FLAG_COURIER_BIT]) cour++;
      end
    end
    rep.status   = st;
    rep.slot     = SLOT_OUT_W'(slot);
    rep.dest     = dest;
    rep.opcode   = op;
    rep.flags    = flags;
    rep.len      = len;
    rep.pending  = COUNT_W'(pend);
    rep.couriers = COUNT_W'(cour);
    rep.last     = last_flag;
    awaited_reports.push_back(rep);
  endfunction

  // Work out the results of one accepted transaction and update the table copy.
  function automatic void predict_slot_events(msg_event_t ev);
    bit [DEST_W-1:0] d;
    bit [TIME_W-1:0] ttl;
    bit [TIME_W-1:0] age;
    int target;
    int oldest_norm;
    int oldest_cour;
    status_t st;
    d = ev.dest & ID_MASK;
    if (!ev.kind) begin
      if (ev.len > MAX_LEN) begin
        queue_report(ST_REJECTED, 0, d, ev.opcode, ev.flags, ev.len, 1'b1);
        return;
      end
      target = -1;
      oldest_norm = -1;
      oldest_cour = -1;
      // Lowest free slot, while tracking the oldest entry of each class.
      for (int i = 0; i < SLOTS; i++) begin
        if (target < 0) begin
          if (!slot_used[i]) begin
            target = i;
          end else if (slot_flags[i][FLAG_COURIER_BIT]) begin
            if (oldest_cour < 0 || slot_seq[i] < slot_seq[oldest_cour]) oldest_cour = i;
          end else begin
            if (oldest_norm < 0 || slot_seq[i] < slot_seq[oldest_norm]) oldest_norm = i;
          end
        end
      end
      st = ST_STORED_FREE;
      if (target < 0) begin
        target = (oldest_norm >= 0) ? oldest_norm : oldest_cour;
        st = ST_STORED_EVICT;
      end
      seq_counter++;
      slot_dest[target]   = d;
      slot_flags[target]  = ev.flags;
      slot_opcode[target] = ev.opcode;
      slot_len[target]    = ev.len;
      slot_seq[target]    = seq_counter;
      slot_stamp[target]  = ev.now;
      slot_used[target]   = 1'b1;
      queue_report(st, target, d, ev.opcode, ev.flags, ev.len, 1'b1);
    end else begin
      // Online scan: expire, then deliver or defer matching entries.
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) begin
          ttl = slot_flags[i][FLAG_COURIER_BIT] ? ttl_courier : ttl_normal;
          age = ev.now - slot_stamp[i];
          if (age > ttl) begin
            slot_used[i] = 1'b0;
            queue_report(ST_EXPIRED, i, slot_dest[i], slot_opcode[i], slot_flags[i],
                         slot_len[i], 1'b0);
          end else if (slot_dest[i] == d) begin
            if (ev.accept) begin
              slot_used[i] = 1'b0;
              queue_report(ST_DELIVERED, i, slot_dest[i], slot_opcode[i], slot_flags[i],
                           slot_len[i], 1'b0);
            end else begin
              queue_report(ST_DEFERRED, i, slot_dest[i], slot_opcode[i], slot_flags[i],
                           slot_len[i], 1'b0);
            end
          end
        end
      end
      queue_report(ST_DONE, 0, '0, '0, '0, '0, 1'b1);
    end
  endfunction

  // Sender: presents queued transactions, with random gaps between them.
  always @(posedge clk) begin
    msg_event_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (offered_msgs.size() > 0) begin
        if (idle_en && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          nxt = offered_msgs.pop_front();
          in_kind        <= nxt.kind;
          in_dest_id     <= nxt.dest;
          in_msg_flags   <= nxt.flags;
          in_msg_opcode  <= nxt.opcode;
          in_payload_len <= nxt.len;
          in_now_ms      <= nxt.now;
          in_tx_accept   <= nxt.accept;
          in_valid       <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: register writes, result checks, then prediction of new transactions.
  always @(posedge clk) begin
    slot_report_t want;
    msg_event_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NORMAL_TTL) ttl_normal = cfg_data;
        else ttl_courier = cfg_data;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_reports.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with none pending (status %0d)",
                                  results_seen, out_status));
        end else begin
          want = awaited_reports.pop_front();
          check_field("status", 64'(out_status), 64'(want.status));
          check_field("slot", 64'(out_slot), 64'(want.slot));
          check_field("dest", out_dest, want.dest);
          check_field("opcode", 64'(out_opcode), 64'(want.opcode));
          check_field("flags", 64'(out_flags), 64'(want.flags));
          check_field("len", 64'(out_len), 64'(want.len));
          check_field("pending_count", 64'(out_pending_count), 64'(want.pending));
          check_field("courier_count", 64'(out_courier_count), 64'(want.couriers));
          check_field("last", 64'(out_last), 64'(want.last));
        end
      end
      if (in_valid && !in_stall) begin
        seen.kind   = in_kind;
        seen.dest   = in_dest_id;
        seen.flags  = in_msg_flags;
        seen.opcode = in_msg_opcode;
        seen.len    = in_payload_len;
        seen.now    = in_now_ms;
        seen.accept = in_tx_accept;
        items_accepted++;
        predict_slot_events(seen);
      end
    end
  end

  task automatic add_enqueue(bit [DEST_W-1:0] dest, bit [FLAGS_W-1:0] flags,
                             bit [OP_W-1:0] op, bit [LEN_W-1:0] len, bit [TIME_W-1:0] now);
    msg_event_t ev;
    ev.kind = 1'b0;
    ev.dest = dest;
    ev.flags = flags;
    ev.opcode = op;
    ev.len = len;
    ev.now = now;
    ev.accept = 1'($urandom_range(0, 1));
    offered_msgs.push_back(ev);
    items_queued++;
  endtask

  task automatic add_online(bit [DEST_W-1:0] dest, bit [TIME_W-1:0] now, bit accept);
    msg_event_t ev;
    ev.kind = 1'b1;
    ev.dest = dest;
    ev.flags = FLAGS_W'($urandom_range(0, 7));
    ev.opcode = OP_W'($urandom_range(0, 255));
    ev.len = LEN_W'($urandom_range(0, 1023));
    ev.now = now;
    ev.accept = accept;
    offered_msgs.push_back(ev);
    items_queued++;
  endtask

  function automatic bit [DEST_W-1:0] pool_dest();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return dest_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Mostly storable lengths, now and then one that is too long.
  function automatic bit [LEN_W-1:0] random_len();
    if ($urandom_range(0, 7) == 0) return LEN_W'($urandom_range(MAX_LEN + 1, 1023));
    return LEN_W'($urandom_range(0, MAX_LEN));
  endfunction

  // Time mostly creeps forward, sometimes jumps far enough to age entries out.
  task automatic advance_clock();
    case ($urandom_range(0, 29))
      0:       wall_ms = $urandom;
      1, 2, 3: wall_ms = wall_ms + $urandom_range(0, 200000);
      default: wall_ms = wall_ms + $urandom_range(0, 3000);
    endcase
  endtask

  // Random traffic: enqueue bursts, visits, overfills, raw noise and lifetime-boundary visits.
  task automatic random_traffic(int count);
    int added;
    int burst;
    bit courier;
    bit [FLAGS_W-1:0] force_flags;
    bit [DEST_W-1:0] d;
    bit [TIME_W-1:0] ttl;
    msg_event_t ev;
    added = 0;
    while (added < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          burst = $urandom_range(1, 8);
          for (int k = 0; k < burst; k++) begin
            advance_clock();
            add_enqueue(pool_dest(), FLAGS_W'($urandom_range(0, 7)),
                        OP_W'($urandom_range(0, 255)), random_len(), wall_ms);
          end
          added += burst;
        end
        5, 6: begin
          advance_clock();
          add_online(pool_dest(), wall_ms, 1'($urandom_range(0, 1)));
          added++;
        end
        7: begin
          // Overfill the table; all-courier fills force courier eviction.
          burst = $urandom_range(17, 20);
          force_flags = $urandom_range(0, 1) ? 3'b100 : 3'b000;
          for (int k = 0; k < burst; k++) begin
            wall_ms = wall_ms + $urandom_range(0, 50);
            add_enqueue(pool_dest(), FLAGS_W'($urandom_range(0, 7)) | force_flags,
                        OP_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, MAX_LEN)),
                        wall_ms);
          end
          add_online(pool_dest(), wall_ms, 1'($urandom_range(0, 1)));
          added += burst + 1;
        end
        8: begin
          // Raw noise over the whole range of every field.
          ev.kind = 1'($urandom_range(0, 1));
          ev.dest = {$urandom, $urandom};
          ev.flags = FLAGS_W'($urandom_range(0, 7));
          ev.opcode = OP_W'($urandom_range(0, 255));
          ev.len = LEN_W'($urandom_range(0, 1023));
          ev.now = $urandom;
          ev.accept = 1'($urandom_range(0, 1));
          offered_msgs.push_back(ev);
          items_queued++;
          added++;
        end
        default: begin
          // Visit exactly at the lifetime boundary, then one millisecond past it.
          d = pool_dest();
          courier = 1'($urandom_range(0, 1));
          ttl = courier ? plan_ttl_courier : plan_ttl_normal;
          advance_clock();
          add_enqueue(d, {courier, 2'($urandom_range(0, 3))}, OP_W'($urandom_range(0, 255)),
                      LEN_W'($urandom_range(0, MAX_LEN)), wall_ms);
          add_online(d, wall_ms + ttl, 1'b0);
          add_online(d, wall_ms + ttl + 1, 1'($urandom_range(0, 1)));
          wall_ms = wall_ms + ttl + 1;
          added += 3;
        end
      endcase
    end
  endtask

  task automatic write_ttl(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_NORMAL_TTL) plan_ttl_normal = value;
    else plan_ttl_courier = value;
  endtask

  // Wait until every transaction is taken and every result has come back.
  task automatic wait_drained();
    int waited;
    waited = 0;
    while ((items_accepted != items_queued || awaited_reports.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (items_accepted != items_queued)
      note_mismatch($sformatf("%0d input transactions never accepted",
                              items_queued - items_accepted));
    if (awaited_reports.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_reports.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence: reset, directed cases, then phases under several lifetimes.
  initial begin
    dest_pool[0] = '0;
    dest_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) dest_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the fields, rejections, wrap-around age and exact lifetimes.
    add_enqueue('1, 3'b111, 8'hFF, LEN_W'(MAX_LEN), 32'hFFFF_FFF0);
    add_enqueue(64'h1234, 3'b001, 8'h5A, LEN_W'(MAX_LEN + 1), 32'd10);
    add_enqueue('1, 3'b111, 8'hFF, 10'd1023, 32'hFFFF_FFFF);
    add_enqueue('0, 3'b000, 8'h00, 10'd0, 32'd0);
    add_enqueue(64'hA5A5_5A5A_F00F_0FF0, 3'b010, 8'h81, 10'd1, 32'd100);
    add_online('1, 32'd5, 1'b0);
    add_online('1, 32'd6, 1'b1);
    add_enqueue(64'd5, 3'b000, 8'h03, 10'd10, 32'd1000);
    add_online(64'd5, 32'd1000 + NORMAL_TTL_RESET, 1'b0);
    add_online(64'd5, 32'd1000 + NORMAL_TTL_RESET + 1, 1'b1);
    add_enqueue(64'd7, 3'b100, 8'h09, 10'd20, 32'd50);
    add_online(64'd7, 32'd50 + COURIER_TTL_RESET, 1'b1);
    add_online(64'd9, 32'd0, 1'b1);
    random_traffic(75);
    wait_drained();

    // Normal entries expire at once, courier entries never.
    write_ttl(CFG_NORMAL_TTL, 32'd0);
    write_ttl(CFG_COURIER_TTL, 32'hFFFF_FFFF);
    random_traffic(90);
    wait_drained();

    // Swapped extremes, with a long receiver hold-off to back up the input.
    write_ttl(CFG_NORMAL_TTL, 32'hFFFF_FFFF);
    write_ttl(CFG_COURIER_TTL, 32'd0);
    random_traffic(90);
    hold_seq <= hold_seq + 1;
    wait_drained();

    write_ttl(CFG_NORMAL_TTL, 32'd20000);
    write_ttl(CFG_COURIER_TTL, 32'd60000);
    random_traffic(90);
    wait_drained();

    // Final stretch at full rate on both sides.
    write_ttl(CFG_NORMAL_TTL, 32'd5000);
    write_ttl(CFG_COURIER_TTL, 32'd5000);
    idle_en <= 1'b0;
    random_traffic(90);
    wait_drained();

    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #12000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
